/* rtl/assert_macros.svh */
// Assertion macros used by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FIR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FIR_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FIR_ASSERT(lbl, clk, rst_n, prop, msg)
`define FIR_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* rtl/fir_pkg.sv */
// Constants and types of the FIR filter.
package fir_pkg;

  localparam int MAX_TAPS    = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_TAPS);
  localparam int TAPCNT_W    = ADDR_W + 1;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int ACC_W       = PROD_W + ADDR_W;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int Q_W         = ACC_W + 1 - FRAC_BITS;
  localparam int TDATA_W     = ((2 * SAMPLE_BITS + ADDR_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_FILTER = 2'd0,
    OP_COEF   = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctrl_t;

endpackage

/* rtl/fir_convolution_filter.sv */
// Top level of the direct-form FIR filter.
//
// Input requests arrive on s_axis: tuser holds the opcode (filter a sample,
// write a coefficient, clear the sample history), tdata the operands.
// Coefficient writes and clears complete in the cycle they are accepted.
// A filter request runs from acceptance through the tap walk, a drain of the
// read and multiply registers and the output step, and the next request is
// taken only after the result is loaded into the output register:
// one multiply-accumulate walks the taps one per cycle, reading the
// coefficient and history memories through their single registered read
// ports, then the sum is rounded and loaded into the output register.
// s_axis_tready is low while a filter request is in progress.
// The result waits in the output register on m_axis until taken; a stalled
// receiver holds the block in its last step, but while idle the block
// still takes coefficient or clear requests while a result waits. The user
// must write tap_count over the cfg channel only while the block is idle,
// which it does not enforce. Values above 64 act as 64, zero gives a zero
// result. Reset (rst_ni low, asynchronous) empties the output, sets
// tap_count to 1 and marks all coefficients and history entries as zero.
`include "assert_macros.svh"

module fir_convolution_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // sample_in[15:0], coef_index[21:16], coef_value[37:22], zero fill
  input  logic [fir_pkg::TDATA_W-1:0]    s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // sample_out[15:0]
  output logic [fir_pkg::SAMPLE_BITS-1:0] m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fir_pkg::TAPCNT_W-1:0]   cfg_data_i
);
  import fir_pkg::*;

  state_e                        state_q, state_d;
  logic [TAPCNT_W-1:0]           tap_count_q;
  logic [TAPCNT_W-1:0]           taps_eff;
  logic [TAPCNT_W-1:0]           j_q;
  logic [ADDR_W-1:0]             wr_pos_q;
  logic                          rd_vld_q;
  logic [MAX_TAPS-1:0]           tap_vld_q;
  logic [MAX_TAPS-1:0]           hist_vld_q;
  logic                          tap_ok_q, hist_ok_q;
  logic [SAMPLE_BITS-1:0]        tap_mem  [MAX_TAPS];
  logic [SAMPLE_BITS-1:0]        hist_mem [MAX_TAPS];
  logic [SAMPLE_BITS-1:0]        tap_rd_q, hist_rd_q;
  logic                          out_vld_q;
  logic [SAMPLE_BITS-1:0]        out_data_q;

  opcode_e                       op;
  logic                          in_acc;
  logic                          issue;
  logic                          out_load;
  logic [ADDR_W-1:0]             tap_ra, hist_ra;
  logic [SAMPLE_BITS-1:0]        in_sample, in_coef;
  logic [ADDR_W-1:0]             in_idx;
  mac_ctrl_t                     mac_ctrl;
  logic signed [SAMPLE_BITS-1:0] mac_a, mac_b, mac_res;
  logic                          mac_busy;

  assign op        = opcode_e'(s_axis_tuser);
  assign in_sample = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_idx    = s_axis_tdata[SAMPLE_BITS +: ADDR_W];
  assign in_coef   = s_axis_tdata[SAMPLE_BITS+ADDR_W +: SAMPLE_BITS];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign taps_eff = (tap_count_q > TAPCNT_W'(MAX_TAPS)) ? TAPCNT_W'(MAX_TAPS) : tap_count_q;
  assign issue    = (state_q == S_MAC) && (j_q < taps_eff);
  assign out_load = (state_q == S_OUT) && (!out_vld_q || m_axis_tready);
  assign tap_ra   = j_q[ADDR_W-1:0];
  assign hist_ra  = wr_pos_q - j_q[ADDR_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && op == OP_FILTER) state_d = S_MAC;
      end
      S_MAC: begin
        if (!issue || (j_q + 1'b1 == taps_eff)) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!rd_vld_q && !mac_busy) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tap_count_q <= TAPCNT_W'(1);
      j_q         <= '0;
      wr_pos_q    <= '0;
      rd_vld_q    <= 1'b0;
      tap_vld_q   <= '0;
      hist_vld_q  <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (cfg_valid_i) tap_count_q <= cfg_data_i;
      if (issue) j_q <= j_q + 1'b1;
      if (in_acc) begin
        case (op)
          OP_FILTER: begin
            j_q                  <= '0;
            hist_vld_q[wr_pos_q] <= 1'b1;
          end
          OP_COEF: tap_vld_q[in_idx] <= 1'b1;
          OP_CLEAR: begin
            hist_vld_q <= '0;
            wr_pos_q   <= '0;
          end
          default: ;
        endcase
      end
      if (out_load) begin
        wr_pos_q  <= wr_pos_q + 1'b1;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && op == OP_COEF) tap_mem[in_idx] <= in_coef;
    tap_rd_q <= tap_mem[tap_ra];
    tap_ok_q <= tap_vld_q[tap_ra];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && op == OP_FILTER) hist_mem[wr_pos_q] <= in_sample;
    hist_rd_q <= hist_mem[hist_ra];
    hist_ok_q <= hist_vld_q[hist_ra];
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= mac_res;
  end

  assign mac_ctrl.clr = in_acc && (op == OP_FILTER);
  assign mac_ctrl.en  = rd_vld_q;
  assign mac_a        = tap_ok_q ? tap_rd_q : '0;
  assign mac_b        = hist_ok_q ? hist_rd_q : '0;

  fir_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .busy_o (mac_busy),
    .res_o  (mac_res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  `FIR_ASSERT(a_filter_starts, clk_i, rst_ni, (in_acc && op == OP_FILTER) |=> (state_q == S_MAC), "filter request did not start the tap walk")
  `FIR_NEVER(a_tap_range, clk_i, rst_ni, (state_q != S_IDLE) && (j_q > taps_eff), "tap counter ran past tap count")
  `FIR_ASSERT(a_out_source, clk_i, rst_ni, $rose(out_vld_q) |-> $past(state_q == S_OUT), "result loaded outside output step")
  `FIR_ASSERT(a_read_in_walk, clk_i, rst_ni, rd_vld_q |-> (state_q == S_MAC || state_q == S_DRAIN), "memory read outstanding outside tap walk")

endmodule

/* rtl/fir_mac.sv */
// Shared multiply-accumulate unit with round and saturate.
module fir_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fir_pkg::mac_ctrl_t                     ctrl_i,
  input  logic signed [fir_pkg::SAMPLE_BITS-1:0] a_i,
  input  logic signed [fir_pkg::SAMPLE_BITS-1:0] b_i,
  output logic                                   busy_o,
  output logic signed [fir_pkg::SAMPLE_BITS-1:0] res_o
);
  import fir_pkg::*;

  logic signed [PROD_W-1:0]  prod_q;
  logic                      prod_vld_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ACC_W:0]     rnd;
  logic signed [Q_W-1:0]     quo;
  logic                      ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.en;
      if (ctrl_i.clr) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // round half up, then clamp to the sample range
  assign rnd = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(1 << (FRAC_BITS - 1));
  assign quo = rnd[ACC_W:FRAC_BITS];
  assign ovf = (quo[Q_W-1:SAMPLE_BITS-1] != '0) && (quo[Q_W-1:SAMPLE_BITS-1] != '1);

  always_comb begin
    if (ovf) begin
      res_o = quo[Q_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      res_o = quo[SAMPLE_BITS-1:0];
    end
  end

  assign busy_o = prod_vld_q;

endmodule

/* bench/fir_convolution_filter_checker.sv */
// Checker for the FIR filter: predicts each filtered sample and compares it.
module fir_convolution_filter_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // sample_in[15:0], coef_index[21:16], coef_value[37:22], zero fill
  input  logic [fir_pkg::TDATA_W-1:0]      s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]                       s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // sample_out[15:0]
  input  logic [fir_pkg::SAMPLE_BITS-1:0]  m_axis_tdata,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_o,
  input  logic [fir_pkg::TAPCNT_W-1:0]     cfg_data_i,
  output int                               error_count_o,
  output int                               samples_due_o
);
  import fir_pkg::*;

  localparam longint ACC_CAP = 64'sd1 <<< 62;
  localparam longint OUT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));

  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] history  [MAX_TAPS];
  logic [ADDR_W-1:0]             wr_pos;
  logic [TAPCNT_W-1:0]           taps_in_use;
  logic [SAMPLE_BITS-1:0]        filtered_due [$];
  int                            errors;

  assign error_count_o = errors;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  initial begin
    errors        = 0;
    samples_due_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    longint                 acc;
    longint                 rnd;
    int                     n;
    int                     j;
    logic [ADDR_W-1:0]      slot;
    logic [SAMPLE_BITS-1:0] want;
    if (!rst_ni) begin
      for (j = 0; j < MAX_TAPS; j++) begin
        coef_mem[j] = '0;
        history[j]  = '0;
      end
      wr_pos      = '0;
      taps_in_use = TAPCNT_W'(1);
      filtered_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        taps_in_use = cfg_data_i;
      end
      // results leave before a new request can add one
      if (m_axis_tvalid && m_axis_tready) begin
        if (filtered_due.size() == 0) begin
          report($sformatf("sample_out %0d with none expected", $signed(m_axis_tdata)));
        end else begin
          want = filtered_due.pop_front();
          if (m_axis_tdata !== want) begin
            report($sformatf("sample_out %0d, expected %0d",
                             $signed(m_axis_tdata), $signed(want)));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          OP_COEF: begin
            coef_mem[s_axis_tdata[21:16]] = s_axis_tdata[37:22];
          end
          OP_CLEAR: begin
            for (j = 0; j < MAX_TAPS; j++) begin
              history[j] = '0;
            end
            wr_pos = '0;
          end
          OP_FILTER: begin
            history[wr_pos] = s_axis_tdata[15:0];
            n   = (taps_in_use > MAX_TAPS) ? MAX_TAPS : int'(taps_in_use);
            acc = 0;
            for (j = 0; j < n; j++) begin
              slot = wr_pos - ADDR_W'(j);
              acc += longint'(history[slot]) * longint'(coef_mem[j]);
              if (acc > ACC_CAP) acc = ACC_CAP;
              if (acc < -ACC_CAP) acc = -ACC_CAP;
            end
            rnd = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (rnd > OUT_MAX) rnd = OUT_MAX;
            if (rnd < OUT_MIN) rnd = OUT_MIN;
            filtered_due.push_back(rnd[SAMPLE_BITS-1:0]);
            wr_pos = wr_pos + 1'b1;
          end
          default: ;
        endcase
      end
    end
    samples_due_o = filtered_due.size();
  end

endmodule

/* bench/fir_convolution_filter_tb.sv */
// Testbench top for the FIR filter: clock, reset, requests and verdict.
module fir_convolution_filter_tb;
  import fir_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         TAIL       = 80;
  localparam int         CYCLE_LIMIT = 400000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_W-1:0]     s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [SAMPLE_BITS-1:0] m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [TAPCNT_W-1:0]    cfg_data_i = '0;
  logic                   calm = 1'b0;
  int                     error_count;
  int                     samples_due;
  int                     cycle_count = 0;

  fir_convolution_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  fir_convolution_filter_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .error_count_o (error_count),
    .samples_due_o (samples_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // returns at the edge where the request is taken
  task automatic send_request(input logic [1:0] op, input logic [15:0] sample,
                              input logic [5:0] idx, input logic [15:0] coef);
    while (!calm && $urandom_range(0, 99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, coef, idx, sample};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (samples_due != 0);
    repeat (TAIL) @(posedge clk_i);
  endtask

  task automatic set_taps(input logic [TAPCNT_W-1:0] taps);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= taps;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2, 3:    return 16'($signed($urandom_range(0, 511)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_phase(input logic [TAPCNT_W-1:0] taps, input int count);
    int         done;
    int         pick;
    logic [1:0] op;
    logic [5:0] idx;
    set_taps(taps);
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      op   = (pick < 70) ? OP_FILTER : (pick < 85) ? OP_COEF :
             (pick < 93) ? OP_CLEAR : OP_UNUSED;
      idx  = $urandom_range(0, 1) ? 6'($urandom_range(0, 7)) : 6'($urandom);
      send_request(op, pick_value(), idx, pick_value());
      if (op != OP_UNUSED) done++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single tap: saturation, rounding half up, negative rounding
    send_request(OP_COEF,   16'h0000, 6'd0,  16'h8000);
    send_request(OP_FILTER, 16'h8000, 6'd0,  16'h0000);
    send_request(OP_FILTER, 16'h7fff, 6'd0,  16'h0000);
    send_request(OP_COEF,   16'h0000, 6'd0,  16'h0001);
    send_request(OP_FILTER, 16'h4000, 6'd0,  16'h0000);
    send_request(OP_FILTER, 16'hc000, 6'd0,  16'h0000);
    send_request(OP_FILTER, 16'hbfff, 6'd0,  16'h0000);
    send_request(OP_COEF,   16'h0000, 6'd0,  16'h7fff);
    send_request(OP_COEF,   16'h0000, 6'd63, 16'h8000);
    send_request(OP_COEF,   16'h0000, 6'd1,  16'h8000);
    send_request(OP_UNUSED, 16'h7fff, 6'd0,  16'h1234);
    send_request(OP_FILTER, 16'h8000, 6'd0,  16'h0000);
    send_request(OP_CLEAR,  16'h0000, 6'd0,  16'h0000);
    send_request(OP_FILTER, 16'h0000, 6'd0,  16'h0000);
    // no taps: zero out, history still written
    set_taps(TAPCNT_W'(0));
    send_request(OP_FILTER, 16'h7fff, 6'd0,  16'h0000);
    send_request(OP_FILTER, 16'h8000, 6'd0,  16'h0000);
    // full length, history kept across the change
    set_taps(TAPCNT_W'(64));
    send_request(OP_FILTER, 16'h8000, 6'd0,  16'h0000);
    send_request(OP_FILTER, 16'h8000, 6'd0,  16'h0000);
    send_request(OP_CLEAR,  16'h0000, 6'd0,  16'h0000);
    send_request(OP_FILTER, 16'h7fff, 6'd0,  16'h0000);

    run_phase(TAPCNT_W'(64), 120);
    run_phase(TAPCNT_W'(127), 50);
    run_phase(TAPCNT_W'(2), 60);
    run_phase(TAPCNT_W'(3), 70);
    run_phase(TAPCNT_W'(65), 40);
    run_phase(TAPCNT_W'($urandom_range(4, 63)), 100);
    run_phase(TAPCNT_W'(1), 60);
    run_phase(TAPCNT_W'(0), 20);
    calm <= 1'b1;
    run_phase(TAPCNT_W'(17), 80);
    calm <= 1'b0;

    drain();
    if (error_count == 0 && samples_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* fir_convolution_filter.f */
+incdir+rtl
rtl/fir_pkg.sv
rtl/fir_mac.sv
rtl/fir_convolution_filter.sv
bench/fir_convolution_filter_checker.sv
bench/fir_convolution_filter_tb.sv
